// ===== hdl/gha_pkg.sv =====
package gha_pkg;

    localparam int DEF_MAX_HANDLES    = 1024;
    localparam int DEF_VERSION_BITS   = 16;
    localparam int DEF_SIGNATURE_BITS = 32;

    localparam int ID_W   = 10;
    localparam int VER_W  = 16;
    localparam int SIG_W  = 32;

    typedef enum logic [2:0] {
        ACT_CREATE      = 3'd0,
        ACT_DESTROY     = 3'd1,
        ACT_DESTROY_ALL = 3'd2,
        ACT_CHECK_ALIVE = 3'd3,
        ACT_GET_SIG     = 3'd4,
        ACT_SET_SIG     = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef struct packed {
        action_t            action;
        logic [ID_W-1:0]    entity_id;
        logic [VER_W-1:0]   entity_version;
        logic [SIG_W-1:0]   signature_in;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    new_id;
        logic [VER_W-1:0]   new_version;
        logic               alive_flag;
        logic [SIG_W-1:0]   signature_out;
    } rsp_t;

endpackage

// ===== hdl/generational_handle_allocator.sv =====
// Generational handle allocator. A handle is an id plus a version; free ids
// wait in a FIFO held in one RAM, and each id's alive bit, version and
// signature word share one entry of a second RAM. Requests run one at a time:
// check_alive, destroy, get/set_signature go from acceptance through a RAM
// read, then modify/write back; create first reads the FIFO head, and that
// read must finish before the entry of the popped id can be read; and
// destroy_all walks every entry of the entry RAM, one id per cycle, in
// ascending order. After reset the block runs an initialization sweep (FIFO
// loaded with the ascending ids, entries cleared) with s_ready low. A new item
// is accepted while the previous result still waits in the output register;
// it only stalls at the point where its own result would be loaded.
module generational_handle_allocator #(
    parameter int MAX_HANDLES    = gha_pkg::DEF_MAX_HANDLES,
    parameter int VERSION_BITS   = gha_pkg::DEF_VERSION_BITS,
    parameter int SIGNATURE_BITS = gha_pkg::DEF_SIGNATURE_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  gha_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output gha_pkg::rsp_t m_data
);

    localparam int IDW   = $clog2(MAX_HANDLES);
    localparam int CNTW  = $clog2(MAX_HANDLES + 1);
    localparam int VB    = VERSION_BITS;
    localparam int SB    = SIGNATURE_BITS;
    localparam int ENT_W = 1 + VB + SB;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_FETCH = 5'b00100,
        S_WALK  = 5'b01000,
        S_EXEC  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    gha_pkg::req_t   req_reg, req_next;
    logic [IDW-1:0]  head_reg, head_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;       // init / walk position
    logic            pend_reg, pend_next;     // walk read in flight
    logic [IDW-1:0]  pend_id_reg, pend_id_next;
    logic            m_valid_reg, m_valid_next;
    gha_pkg::rsp_t   m_data_reg, m_data_next;

    // Free-id FIFO RAM ports
    logic            q_wr_en, q_rd_en;
    logic [IDW-1:0]  q_wr_addr, q_wr_data, q_rd_addr, q_rd_data;
    // Entry RAM ports: {alive, version, signature}
    logic             e_wr_en, e_rd_en;
    logic [IDW-1:0]   e_wr_addr, e_rd_addr;
    logic [ENT_W-1:0] e_wr_data, e_rd_data;

    logic            e_alive;
    logic [VB-1:0]   e_ver;
    logic [SB-1:0]   e_sig;
    logic [IDW:0]    tail_sum;
    logic [IDW-1:0]  tail;
    logic [IDW-1:0]  head_inc;
    logic [IDW-1:0]  cnt_id;
    logic            in_range, live, out_free, can_push;

    gha_ram #(.WIDTH(IDW), .DEPTH(MAX_HANDLES)) u_free_ram (
        .aclk    (aclk),
        .wr_en   (q_wr_en),
        .wr_addr (q_wr_addr),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_addr (q_rd_addr),
        .rd_data (q_rd_data)
    );

    gha_ram #(.WIDTH(ENT_W), .DEPTH(MAX_HANDLES)) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (e_wr_en),
        .wr_addr (e_wr_addr),
        .wr_data (e_wr_data),
        .rd_en   (e_rd_en),
        .rd_addr (e_rd_addr),
        .rd_data (e_rd_data)
    );

    assign e_alive = e_rd_data[ENT_W-1];
    assign e_ver   = e_rd_data[SB+VB-1:SB];
    assign e_sig   = e_rd_data[SB-1:0];

    // Push slot: head + count, wrapped once.
    assign tail_sum = (IDW+1)'(head_reg) + (IDW+1)'(count_reg);
    assign tail     = (32'(tail_sum) >= MAX_HANDLES)
                    ? IDW'(tail_sum - (IDW+1)'(MAX_HANDLES)) : IDW'(tail_sum);
    assign head_inc = (head_reg == IDW'(MAX_HANDLES - 1)) ? '0 : head_reg + 1'b1;
    assign can_push = (32'(count_reg) < MAX_HANDLES);
    assign cnt_id   = cnt_reg[IDW-1:0];

    // Handle checks against the entry read for the latched request.
    assign in_range = (32'(req_reg.entity_id) < MAX_HANDLES);
    assign live     = in_range && e_alive
                   && (32'(e_ver) == 32'(req_reg.entity_version));

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        pend_id_next = pend_id_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        q_wr_en   = 1'b0;
        q_wr_addr = tail;
        q_wr_data = '0;
        q_rd_en   = 1'b0;
        q_rd_addr = head_reg;
        e_wr_en   = 1'b0;
        e_wr_addr = '0;
        e_wr_data = '0;
        e_rd_en   = 1'b0;
        e_rd_addr = IDW'(s_data.entity_id);

        case (state_reg)
            S_INIT: begin
                // FIFO slot i holds id i, entries cleared.
                q_wr_en   = 1'b1;
                q_wr_addr = cnt_id;
                q_wr_data = cnt_id;
                e_wr_en   = 1'b1;
                e_wr_addr = cnt_id;
                e_wr_data = '0;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(MAX_HANDLES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    e_rd_en  = 1'b1;
                    case (s_data.action)
                        gha_pkg::ACT_CREATE: begin
                            q_rd_en    = 1'b1;
                            state_next = S_FETCH;
                        end
                        gha_pkg::ACT_DESTROY_ALL: begin
                            e_rd_en    = 1'b0;
                            cnt_next   = '0;
                            pend_next  = 1'b0;
                            state_next = S_WALK;
                        end
                        default: begin
                            state_next = S_EXEC;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                // Popped id is known now; fetch its entry.
                e_rd_en    = 1'b1;
                e_rd_addr  = q_rd_data;
                state_next = S_EXEC;
            end
            S_WALK: begin
                // Read id cnt while writing back id cnt-1.
                if (32'(cnt_reg) < MAX_HANDLES) begin
                    e_rd_en      = 1'b1;
                    e_rd_addr    = cnt_id;
                    cnt_next     = cnt_reg + 1'b1;
                    pend_next    = 1'b1;
                    pend_id_next = cnt_id;
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_EXEC;
                end
                if (pend_reg) begin
                    e_wr_en   = 1'b1;
                    e_wr_addr = pend_id_reg;
                    e_wr_data = {1'b0, (e_alive ? VB'(e_ver + 1'b1) : e_ver), SB'(0)};
                    if (e_alive && can_push) begin
                        q_wr_en    = 1'b1;
                        q_wr_data  = pend_id_reg;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    state_next   = S_IDLE;
                    e_wr_addr    = IDW'(req_reg.entity_id);
                    case (req_reg.action)
                        gha_pkg::ACT_CREATE: begin
                            if (count_reg == '0) begin
                                m_data_next.status = gha_pkg::ST_FULL;
                            end else begin
                                e_wr_en    = 1'b1;
                                e_wr_addr  = q_rd_data;
                                e_wr_data  = {1'b1, e_ver, e_sig};
                                head_next  = head_inc;
                                count_next = count_reg - 1'b1;
                                m_data_next.new_id      = gha_pkg::ID_W'(q_rd_data);
                                m_data_next.new_version = gha_pkg::VER_W'(e_ver);
                            end
                        end
                        gha_pkg::ACT_DESTROY: begin
                            if (live) begin
                                e_wr_en   = 1'b1;
                                e_wr_data = {1'b0, VB'(e_ver + 1'b1), SB'(0)};
                                if (can_push) begin
                                    q_wr_en    = 1'b1;
                                    q_wr_data  = IDW'(req_reg.entity_id);
                                    count_next = count_reg + 1'b1;
                                end
                            end else begin
                                m_data_next.status = gha_pkg::ST_INVALID;
                            end
                        end
                        gha_pkg::ACT_DESTROY_ALL: begin
                            m_data_next.status = gha_pkg::ST_OK;
                        end
                        gha_pkg::ACT_CHECK_ALIVE: begin
                            m_data_next.alive_flag = live;
                        end
                        gha_pkg::ACT_GET_SIG: begin
                            if (in_range) begin
                                m_data_next.signature_out = gha_pkg::SIG_W'(e_sig);
                            end else begin
                                m_data_next.status = gha_pkg::ST_INVALID;
                            end
                        end
                        gha_pkg::ACT_SET_SIG: begin
                            if (in_range) begin
                                e_wr_en   = 1'b1;
                                e_wr_data = {e_alive, e_ver, SB'(req_reg.signature_in)};
                            end else begin
                                m_data_next.status = gha_pkg::ST_INVALID;
                            end
                        end
                        default: begin
                            // undefined action codes
                            m_data_next.status = gha_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            head_reg    <= '0;
            count_reg   <= CNTW'(MAX_HANDLES);
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        pend_id_reg <= pend_id_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hdl/gha_ram.sv =====
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sim/generational_handle_allocator_tb.sv =====
module generational_handle_allocator_tb;
    import gha_pkg::*;

    localparam int MAXH = DEF_MAX_HANDLES;

    // Directed item: a request plus, where it is obvious, the exact response.
    typedef struct {
        req_t req;
        bit   fixed;
        rsp_t want;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    generational_handle_allocator uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow copy of the allocator: free-id FIFO, versions, alive bits and
    // signature words, plus a list of live ids for building good handles.
    // ------------------------------------------------------------------
    logic [ID_W-1:0]  free_ids [MAXH];
    int unsigned      free_head;
    int unsigned      free_cnt;
    logic [VER_W-1:0] versions [MAXH];
    bit               alive    [MAXH];
    logic [SIG_W-1:0] sigs     [MAXH];
    int unsigned      live_ids [$];

    rsp_t        pending_rsp [$];   // responses still owed by the block
    int unsigned rsp_seen = 0;
    int unsigned errors = 0;
    bit          tx_calm = 1'b0;    // sender never idles while set

    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    // Give an id back: append to the FIFO tail, then bump its version.
    function automatic void recycle_id(input int unsigned id);
        if (free_cnt < MAXH) begin
            free_ids[(free_head + free_cnt) % MAXH] = ID_W'(id);
            free_cnt++;
        end
        versions[id] = versions[id] + 1'b1;
    endfunction

    // Applies one accepted request to the shadow state, returns the response.
    function automatic rsp_t alloc_response(input req_t r);
        rsp_t            o;
        int unsigned     id;
        bit              in_range;
        bit              live;
        logic [ID_W-1:0] got;
        int              hits [$];
        o = '0;
        id = r.entity_id;
        in_range = id < MAXH;
        live = in_range && alive[id] && versions[id] == r.entity_version;
        case (r.action)
            ACT_CREATE: begin
                if (free_cnt == 0) begin
                    o.status = ST_FULL;
                end else begin
                    got = free_ids[free_head];
                    free_head = (free_head + 1) % MAXH;
                    free_cnt--;
                    alive[got] = 1'b1;
                    live_ids.push_back(got);
                    o.new_id = got;
                    o.new_version = versions[got];
                end
            end
            ACT_DESTROY: begin
                if (!live) begin
                    o.status = ST_INVALID;
                end else begin
                    recycle_id(id);
                    alive[id] = 1'b0;
                    sigs[id] = '0;
                    hits = live_ids.find_first_index(x) with (x == id);
                    if (hits.size() > 0) live_ids.delete(hits[0]);
                end
            end
            ACT_DESTROY_ALL: begin
                // live ids go back in ascending id order
                for (int i = 0; i < MAXH; i++) begin
                    if (alive[i]) recycle_id(i);
                    alive[i] = 1'b0;
                    sigs[i] = '0;
                end
                live_ids.delete();
            end
            ACT_CHECK_ALIVE: o.alive_flag = live;
            ACT_GET_SIG: begin
                if (in_range) o.signature_out = sigs[id];
                else o.status = ST_INVALID;
            end
            ACT_SET_SIG: begin
                // dead ids are written too
                if (in_range) sigs[id] = r.signature_in;
                else o.status = ST_INVALID;
            end
            default: o.status = ST_INVALID;
        endcase
        return o;
    endfunction

    function automatic req_t mk_req(input action_t a, input int unsigned id,
                                    input int unsigned ver, input logic [31:0] sig);
        req_t r;
        r.action = a;
        r.entity_id = ID_W'(id);
        r.entity_version = VER_W'(ver);
        r.signature_in = sig;
        return r;
    endfunction

    function automatic rsp_t mk_rsp(input status_t st, input int unsigned id,
                                    input int unsigned ver, input bit aflag,
                                    input logic [31:0] sig);
        rsp_t o;
        o.status = st;
        o.new_id = ID_W'(id);
        o.new_version = VER_W'(ver);
        o.alive_flag = aflag;
        o.signature_out = sig;
        return o;
    endfunction

    function automatic dir_row_t mk_row(input req_t r, input bit fixed, input rsp_t w);
        dir_row_t d;
        d.req = r;
        d.fixed = fixed;
        d.want = w;
        return d;
    endfunction

    // Random request. Mostly well-formed handles taken from the live list,
    // with dead, stale and random handles, bad actions and the odd
    // destroy_all mixed in. In fill mode nearly every item is a create.
    function automatic req_t pick_item(input bit fill);
        req_t        r;
        int unsigned p;
        int unsigned lid;
        int unsigned rid;
        int unsigned sid;
        r = mk_req(ACT_CREATE, $urandom, $urandom, $urandom);
        rid = r.entity_id;
        lid = rid;
        if (live_ids.size() > 0) lid = live_ids[$urandom_range(live_ids.size() - 1)];
        sid = $urandom_range(1) ? lid : rid;
        p = $urandom_range(99);
        if (fill) p = (p < 92) ? 0 : $urandom_range(95, 25);
        if (p < 25) begin
            r.action = ACT_CREATE;
        end else if (p < 40) begin
            r = mk_req(ACT_DESTROY, lid, versions[lid], r.signature_in);
        end else if (p < 46) begin
            // stale version on a known id, or a fully random handle
            if ($urandom_range(1)) r = mk_req(ACT_DESTROY, lid, versions[lid] - 1, 0);
            else r.action = ACT_DESTROY;
        end else if (p < 56) begin
            r = mk_req(ACT_CHECK_ALIVE, lid, versions[lid], r.signature_in);
        end else if (p < 64) begin
            r = mk_req(ACT_CHECK_ALIVE, rid, versions[rid], r.signature_in);
        end else if (p < 76) begin
            r = mk_req(ACT_GET_SIG, sid, r.entity_version, r.signature_in);
        end else if (p < 90) begin
            r = mk_req(ACT_SET_SIG, sid, r.entity_version, r.signature_in);
        end else if (p < 96) begin
            r = mk_req(ACT_CHECK_ALIVE, lid, r.entity_version, r.signature_in);
        end else if (p < 98) begin
            r.action = action_t'($urandom_range(7, 6));
        end else begin
            r.action = ACT_DESTROY_ALL;
        end
        return r;
    endfunction

    // Offer one item at the falling edge, hold it until accepted. valid is
    // only lowered when an idle cycle is actually inserted.
    task automatic send_item(input req_t r, input bit fixed, input rsp_t want);
        rsp_t got;
        @(negedge aclk);
        while (!tx_calm && $urandom_range(99) < 33) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        got = alloc_response(r);
        pending_rsp.push_back(fixed ? want : got);
    endtask

    // Stop offering and wait until every owed response has come back.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Response side: random back-pressure, one long hold-off after 500
    // responses, and a calm window with m_ready held high.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && rsp_seen >= 500) begin
            hold_done <= 1'b1;
            hold_left <= 299;
            m_ready <= 1'b0;
        end else begin
            m_ready <= (rsp_seen >= 900 && rsp_seen < 1100) || ($urandom_range(99) >= 33);
        end
    end

    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected response, expected none, got %p", $time, m_data);
                errors++;
            end else begin
                want = pending_rsp.pop_front();
                check_field("status", want.status, m_data.status);
                check_field("new_id", want.new_id, m_data.new_id);
                check_field("new_version", want.new_version, m_data.new_version);
                check_field("alive_flag", want.alive_flag, m_data.alive_flag);
                check_field("signature_out", want.signature_out, m_data.signature_out);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        dir_row_t    rows [$];
        rsp_t        none;
        int unsigned extra;

        none = '0;
        for (int i = 0; i < MAXH; i++) begin
            free_ids[i] = ID_W'(i);
            versions[i] = '0;
            alive[i] = 1'b0;
            sigs[i] = '0;
        end
        free_head = 0;
        free_cnt = MAXH;

        // nothing alive after reset, all signatures zero
        rows.push_back(mk_row(mk_req(ACT_CHECK_ALIVE, 0, 0, 0), 1, none));
        rows.push_back(mk_row(mk_req(ACT_GET_SIG, 1023, 0, 0), 1, none));
        // FIFO hands out ascending ids, version 0
        rows.push_back(mk_row(mk_req(ACT_CREATE, 0, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 0, 0)));
        rows.push_back(mk_row(mk_req(ACT_CREATE, 1023, 16'hFFFF, 32'hFFFF_FFFF), 1,
                              mk_rsp(ST_OK, 1, 0, 0, 0)));
        rows.push_back(mk_row(mk_req(ACT_CHECK_ALIVE, 0, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 1, 0)));
        rows.push_back(mk_row(mk_req(ACT_CHECK_ALIVE, 0, 16'hFFFF, 0), 1, none));
        rows.push_back(mk_row(mk_req(ACT_SET_SIG, 0, 0, 32'hFFFF_FFFF), 1, none));
        rows.push_back(mk_row(mk_req(ACT_GET_SIG, 0, 0, 0), 1,
                              mk_rsp(ST_OK, 0, 0, 0, 32'hFFFF_FFFF)));
        // signature write to a dead id still lands
        rows.push_back(mk_row(mk_req(ACT_SET_SIG, 1023, 0, 32'hA5A5_5A5A), 0, none));
        rows.push_back(mk_row(mk_req(ACT_GET_SIG, 1023, 0, 0), 1,
                              mk_rsp(ST_OK, 0, 0, 0, 32'hA5A5_5A5A)));
        // stale version, then a dead id
        rows.push_back(mk_row(mk_req(ACT_DESTROY, 0, 1, 0), 1, mk_rsp(ST_INVALID, 0, 0, 0, 0)));
        rows.push_back(mk_row(mk_req(ACT_DESTROY, 1023, 16'hFFFF, 0), 1,
                              mk_rsp(ST_INVALID, 0, 0, 0, 0)));
        rows.push_back(mk_row(mk_req(ACT_DESTROY, 0, 0, 0), 1, none));
        rows.push_back(mk_row(mk_req(ACT_GET_SIG, 0, 0, 0), 1, none));
        rows.push_back(mk_row(mk_req(ACT_CHECK_ALIVE, 0, 0, 0), 1, none));
        rows.push_back(mk_row(mk_req(ACT_DESTROY, 0, 0, 0), 1, mk_rsp(ST_INVALID, 0, 0, 0, 0)));
        // undefined actions
        rows.push_back(mk_row(mk_req(action_t'(3'd6), 5, 0, 0), 1,
                              mk_rsp(ST_INVALID, 0, 0, 0, 0)));
        rows.push_back(mk_row(mk_req(action_t'(3'd7), 1023, 16'hFFFF, 32'hFFFF_FFFF), 1,
                              mk_rsp(ST_INVALID, 0, 0, 0, 0)));
        rows.push_back(mk_row(mk_req(ACT_CREATE, 0, 0, 0), 1, mk_rsp(ST_OK, 2, 0, 0, 0)));
        rows.push_back(mk_row(mk_req(ACT_SET_SIG, 2, 0, 32'h1234_5678), 0, none));
        // destroy_all recycles ids 1 and 2, clears every signature
        rows.push_back(mk_row(mk_req(ACT_DESTROY_ALL, 0, 0, 0), 1, none));
        rows.push_back(mk_row(mk_req(ACT_CHECK_ALIVE, 1, 0, 0), 1, none));
        rows.push_back(mk_row(mk_req(ACT_GET_SIG, 2, 0, 0), 1, none));
        rows.push_back(mk_row(mk_req(ACT_GET_SIG, 1023, 0, 0), 1, none));
        rows.push_back(mk_row(mk_req(ACT_CREATE, 0, 0, 0), 0, none));

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[k]) send_item(rows[k].req, rows[k].fixed, rows[k].want);
        drain();

        // mixed traffic, with a stretch where the sender never idles
        for (int k = 0; k < 200; k++) begin
            tx_calm = (k >= 60 && k < 160);
            send_item(pick_item(1'b0), 1'b0, none);
        end
        tx_calm = 1'b0;

        // create-heavy until the free list runs dry, then keep knocking
        extra = 0;
        while (free_cnt != 0 || extra < 40) begin
            if (free_cnt == 0) extra++;
            send_item(pick_item(free_cnt == 0 ? 1'($urandom_range(1)) : 1'b1), 1'b0, none);
        end
        send_item(mk_req(ACT_DESTROY_ALL, 0, 0, 0), 1'b0, none);
        drain();

        for (int k = 0; k < 200; k++) send_item(pick_item(1'b0), 1'b0, none);
        drain();

        // quiet tail: no stray responses allowed
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending_rsp.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #1600000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== generational_handle_allocator.f =====
hdl/gha_pkg.sv
hdl/gha_ram.sv
hdl/generational_handle_allocator.sv
sim/generational_handle_allocator_tb.sv
